[rtl/core/atd_pkg.sv]
// atd_pkg: shared types, codes, constants and helper functions of the autodiff tape engine
// used by atd_front, atd_queue, atd_back and autodiff_tape_engine; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package atd_pkg;

    // tape geometry
    localparam int TAPE_DEPTH   = 1024;
    localparam int TAPE_AW      = $clog2(TAPE_DEPTH);
    localparam int LEN_W        = TAPE_AW + 1;

    // tanh table geometry, table covers [-4, 4), 2^19 is the span 8.0 in Q16.16
    localparam int TANH_ENTRIES = 256;
    localparam int TANH_BITS    = $clog2(TANH_ENTRIES);
    localparam int TANH_SHIFT   = 19 - TANH_BITS;

    // table build constants: half step, series argument scale and coefficients
    localparam real TANH_HALF_STEP = 4.0 / TANH_ENTRIES;
    localparam int  EXP_SQUARINGS  = 16;
    localparam real EXP_SCALE      = 2.0 / 65536.0;
    localparam real INV_6          = 1.0 / 6.0;
    localparam real INV_24         = 1.0 / 24.0;

    // fixed point
    localparam logic signed [31:0] FX_ONE      = 32'sh0001_0000;
    localparam logic [16:0]        LR_RESET    = 17'd655;

    // command kinds
    typedef enum logic [3:0] {
        K_CONST    = 4'd0,
        K_ADD      = 4'd1,
        K_SUB      = 4'd2,
        K_MUL      = 4'd3,
        K_TANH     = 4'd4,
        K_READ     = 4'd5,
        K_BACKPROP = 4'd6,
        K_ZERO     = 4'd7,
        K_TRUNC    = 4'd8,
        K_DESCEND  = 4'd9
    } t_op;

    // op code kept per tape node
    typedef enum logic [2:0] {
        NODE_CONST = 3'd0,
        NODE_ADD   = 3'd1,
        NODE_SUB   = 3'd2,
        NODE_MUL   = 3'd3,
        NODE_TANH  = 3'd4
    } t_node_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_INDEX = 2'd2,
        ST_MARK  = 2'd3
    } t_status;

    // decoded command word passed from front to back
    typedef struct packed {
        t_op                 op;
        t_node_op            node_op;
        logic                nop;
        logic                is_push;
        logic                use_a;
        logic                use_b;
        logic [TAPE_AW-1:0]  a;
        logic [TAPE_AW-1:0]  b;
        logic [LEN_W-1:0]    mark;
        logic signed [31:0]  cval;
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK,
        S_RDA, S_RDB, S_CALC, S_MULF, S_PWRITE,
        S_RD, S_RDOUT, S_DMUL, S_DUPD,
        S_ZERO,
        S_BNODE, S_BLINK, S_BM1, S_BM2, S_BM3,
        S_BT1, S_BT2, S_BT3, S_BT4,
        S_BAX, S_BAXW, S_BAY, S_BAYW, S_BNEXT
    } t_state;

    typedef logic signed [31:0] t_tanh_tab [TANH_ENTRIES];

    // clamp a wide signed value to 32 bits
    function automatic logic signed [31:0] f_sat32(input logic signed [49:0] x);
        if (x > 50'sd2147483647) begin
            return 32'sh7fff_ffff;
        end else if (x < -50'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    // tanh at each step midpoint, scaled by 65536 and rounded
    function automatic t_tanh_tab f_tanh_table();
        t_tanh_tab tab;
        real    m;
        real    x;
        real    e;
        real    den;
        real    r;
        real    th;
        int     s;
        int     v;
        for (int i = 0; i < TANH_ENTRIES; i++) begin
            s = 2 * i + 1 - TANH_ENTRIES;
            m = ((s < 0) ? -s : s) * TANH_HALF_STEP;
            // exp(-2m) from a short series at a tiny argument, squared back up
            x = m * EXP_SCALE;
            e = 1.0 - x + x * x * 0.5 - x * x * x * INV_6 + x * x * x * x * INV_24;
            for (int j = 0; j < EXP_SQUARINGS; j++) begin
                e = e * e;
            end
            // reciprocal of 1 + e by newton iteration
            den = 1.0 + e;
            r = 0.75;
            for (int j = 0; j < 6; j++) begin
                r = r * (2.0 - den * r);
            end
            th = (1.0 - e) * r;
            v = $rtoi(th * 65536.0 + 0.5);
            tab[i] = (s < 0) ? -32'(v) : 32'(v);
        end
        return tab;
    endfunction

    localparam t_tanh_tab TANH_TABLE = f_tanh_table();

endpackage

`default_nettype wire

[rtl/core/atd_front.sv]
// atd_front: accepts commands, decodes the kind and tracks the item in flight
// depends on atd_pkg
`timescale 1ns / 1ps
`default_nettype none

module atd_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [3:0]          i_kind,
    input  wire logic [9:0]          i_operand_a,
    input  wire logic [9:0]          i_operand_b,
    input  wire logic [10:0]         i_mark,
    input  wire logic signed [31:0]  i_const_value,
    input  wire logic                i_done,
    output logic                     o_push,
    output atd_pkg::t_cmd            o_cmd
);

    logic          r_pend;
    logic          r_push;
    atd_pkg::t_cmd r_cmd;
    atd_pkg::t_cmd n_cmd;
    logic          accept;

    assign accept = start && !r_pend;
    assign busy   = r_pend;
    assign o_push = r_push;
    assign o_cmd  = r_cmd;

    // classify the kind
    always_comb begin
        n_cmd.op      = atd_pkg::t_op'(i_kind);
        n_cmd.node_op = atd_pkg::t_node_op'(i_kind[2:0]);
        n_cmd.nop     = i_kind > 4'(atd_pkg::K_DESCEND);
        n_cmd.is_push = i_kind <= 4'(atd_pkg::K_TANH);
        n_cmd.use_a   = (i_kind >= 4'(atd_pkg::K_ADD) && i_kind <= 4'(atd_pkg::K_BACKPROP))
                        || i_kind == 4'(atd_pkg::K_DESCEND);
        n_cmd.use_b   = i_kind >= 4'(atd_pkg::K_ADD) && i_kind <= 4'(atd_pkg::K_MUL);
        n_cmd.a       = i_operand_a;
        n_cmd.b       = i_operand_b;
        n_cmd.mark    = i_mark;
        n_cmd.cval    = i_const_value;
    end

    // one item in flight until the back end reports it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_push <= 1'b0;
        end else begin
            r_push <= accept;
            if (accept) begin
                r_pend <= 1'b1;
            end else if (i_done) begin
                r_pend <= 1'b0;
            end
        end
    end

    // decoded word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/core/atd_queue.sv]
// atd_queue: two-entry command queue between front and back
// depends on atd_pkg
`timescale 1ns / 1ps
`default_nettype none

module atd_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire atd_pkg::t_cmd  i_cmd,
    input  wire logic           i_pop,
    output logic                o_valid,
    output atd_pkg::t_cmd       o_cmd
);

    atd_pkg::t_cmd r_slot [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          do_pop;
    logic          do_push;

    assign o_valid = r_cnt != 2'd0;
    assign o_cmd   = r_slot[r_rp];
    assign do_pop  = i_pop && o_valid;
    assign do_push = i_push && r_cnt != 2'd2;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/core/atd_back.sv]
// atd_back: executes commands against the tape memories, one at a time
// depends on atd_pkg
`timescale 1ns / 1ps
`default_nettype none

module atd_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_q_valid,
    input  wire atd_pkg::t_cmd       i_q_cmd,
    output logic                     o_pop,
    input  wire logic [16:0]         i_learn_rate,
    output logic                     o_done,
    output logic [1:0]               o_status,
    output logic [9:0]               o_node_index,
    output logic signed [31:0]       o_node_value,
    output logic signed [31:0]       o_node_grad,
    output logic [10:0]              o_tape_length
);

    localparam int AW = atd_pkg::TAPE_AW;
    localparam int LW = atd_pkg::LEN_W;

    // tape memories
    logic signed [31:0]  value_mem  [atd_pkg::TAPE_DEPTH];
    logic signed [31:0]  grad_mem   [atd_pkg::TAPE_DEPTH];
    atd_pkg::t_node_op   op_mem     [atd_pkg::TAPE_DEPTH];
    logic [AW-1:0]       link1_mem  [atd_pkg::TAPE_DEPTH];
    logic [AW-1:0]       link2_mem  [atd_pkg::TAPE_DEPTH];

    atd_pkg::t_state     r_state, n_state;
    atd_pkg::t_cmd       r_cmd;
    logic [LW-1:0]       r_len, n_len;
    logic [LW-1:0]       r_k;
    logic signed [31:0]  r_opa, r_res, r_g, r_vk, r_dx, r_dy;
    atd_pkg::t_node_op   r_op;
    logic [AW-1:0]       r_x, r_y;
    logic signed [64:0]  r_prod;
    logic                r_done;

    // memory ports
    logic [AW-1:0]       va, ga, v_wa, g_wa;
    logic                v_we, g_we, n_we;
    logic signed [31:0]  v_wd, g_wd;
    logic signed [31:0]  r_vrd, r_grd;
    atd_pkg::t_node_op   r_oprd;
    logic [AW-1:0]       r_l1rd, r_l2rd, n_l1;

    // multiplier operands
    logic signed [31:0]  m_a;
    logic signed [32:0]  m_b;

    // finishing word
    logic                fin;
    atd_pkg::t_status    fin_status;
    logic [AW-1:0]       fin_idx;
    logic signed [31:0]  fin_val, fin_grad;

    logic [LW-1:0]       a_ext, b_ext;
    logic                bad_idx;
    logic signed [31:0]  prod_sat, calc_res, desc_res, tanh_val;
    logic signed [32:0]  tanh_t;
    logic [32:0]         tanh_sh;
    logic [atd_pkg::TANH_BITS-1:0] tanh_idx;

    assign a_ext    = LW'(r_cmd.a);
    assign b_ext    = LW'(r_cmd.b);
    assign bad_idx  = (r_cmd.use_a && a_ext >= r_len) || (r_cmd.use_b && b_ext >= r_len);
    assign prod_sat = atd_pkg::f_sat32(50'(r_prod >>> 16));
    assign desc_res = atd_pkg::f_sat32(50'(r_opa) - 50'(r_prod >>> 16));
    assign n_l1     = (r_cmd.node_op == atd_pkg::NODE_CONST) ? r_len[AW-1:0] : r_cmd.a;

    // tanh table index, clamped to the table ends
    always_comb begin
        tanh_t  = 33'(r_opa) + 33'sd262144;
        tanh_sh = 33'(tanh_t >>> atd_pkg::TANH_SHIFT);
        if (tanh_t <= 33'sd0) begin
            tanh_idx = '0;
        end else if (tanh_sh > 33'(atd_pkg::TANH_ENTRIES - 1)) begin
            tanh_idx = atd_pkg::TANH_BITS'(atd_pkg::TANH_ENTRIES - 1);
        end else begin
            tanh_idx = tanh_sh[atd_pkg::TANH_BITS-1:0];
        end
        tanh_val = atd_pkg::TANH_TABLE[tanh_idx];
    end

    // push arithmetic other than multiply
    always_comb begin
        unique case (r_cmd.node_op)
            atd_pkg::NODE_ADD:  calc_res = atd_pkg::f_sat32(50'(r_opa) + 50'(r_vrd));
            atd_pkg::NODE_SUB:  calc_res = atd_pkg::f_sat32(50'(r_opa) - 50'(r_vrd));
            default:            calc_res = tanh_val;
        endcase
    end

    // multiplier operand select
    always_comb begin
        m_a = r_g;
        m_b = 33'(r_vrd);
        unique case (r_state)
            atd_pkg::S_CALC: begin
                m_a = r_opa;
                m_b = 33'(r_vrd);
            end
            atd_pkg::S_DMUL: begin
                m_a = r_grd;
                m_b = $signed({16'd0, i_learn_rate});
            end
            atd_pkg::S_BT1: begin
                m_a = r_vk;
                m_b = 33'(r_vk);
            end
            atd_pkg::S_BT3: begin
                m_a = r_dy;
                m_b = 33'(r_g);
            end
            default: begin
                m_a = r_g;
                m_b = 33'(r_vrd);
            end
        endcase
    end

    // next state, memory control and finishing word
    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        o_pop      = 1'b0;
        va         = r_k[AW-1:0];
        ga         = r_k[AW-1:0];
        v_we       = 1'b0;
        v_wa       = r_len[AW-1:0];
        v_wd       = r_res;
        g_we       = 1'b0;
        g_wa       = r_len[AW-1:0];
        g_wd       = '0;
        n_we       = 1'b0;
        fin        = 1'b0;
        fin_status = atd_pkg::ST_OK;
        fin_idx    = '0;
        fin_val    = '0;
        fin_grad   = '0;
        unique case (r_state)
            atd_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_state = atd_pkg::S_CHECK;
                end
            end
            atd_pkg::S_CHECK: begin
                priority if (r_cmd.nop) begin
                    fin     = 1'b1;
                    n_state = atd_pkg::S_IDLE;
                end else if (bad_idx) begin
                    fin        = 1'b1;
                    fin_status = atd_pkg::ST_INDEX;
                    n_state    = atd_pkg::S_IDLE;
                end else if (r_cmd.is_push) begin
                    if (r_len == LW'(atd_pkg::TAPE_DEPTH)) begin
                        fin        = 1'b1;
                        fin_status = atd_pkg::ST_FULL;
                        n_state    = atd_pkg::S_IDLE;
                    end else if (r_cmd.node_op == atd_pkg::NODE_CONST) begin
                        n_state = atd_pkg::S_PWRITE;
                    end else begin
                        n_state = atd_pkg::S_RDA;
                    end
                end else begin
                    unique case (r_cmd.op)
                        atd_pkg::K_READ, atd_pkg::K_DESCEND: begin
                            n_state = atd_pkg::S_RD;
                        end
                        atd_pkg::K_BACKPROP: begin
                            g_we    = 1'b1;
                            g_wa    = r_cmd.a;
                            g_wd    = atd_pkg::FX_ONE;
                            n_state = atd_pkg::S_BNODE;
                        end
                        atd_pkg::K_ZERO: begin
                            n_state = atd_pkg::S_ZERO;
                        end
                        atd_pkg::K_TRUNC: begin
                            fin     = 1'b1;
                            n_state = atd_pkg::S_IDLE;
                            if (r_cmd.mark > r_len) begin
                                fin_status = atd_pkg::ST_MARK;
                            end else begin
                                n_len = r_cmd.mark;
                            end
                        end
                        default: begin
                            fin     = 1'b1;
                            n_state = atd_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            // push: two operand reads, compute, append
            atd_pkg::S_RDA: begin
                va      = r_cmd.a;
                n_state = atd_pkg::S_RDB;
            end
            atd_pkg::S_RDB: begin
                va      = r_cmd.b;
                n_state = atd_pkg::S_CALC;
            end
            atd_pkg::S_CALC: begin
                n_state = (r_cmd.node_op == atd_pkg::NODE_MUL) ? atd_pkg::S_MULF
                                                               : atd_pkg::S_PWRITE;
            end
            atd_pkg::S_MULF: begin
                n_state = atd_pkg::S_PWRITE;
            end
            atd_pkg::S_PWRITE: begin
                v_we    = 1'b1;
                g_we    = 1'b1;
                n_we    = 1'b1;
                n_len   = r_len + LW'(1);
                fin     = 1'b1;
                fin_idx = r_len[AW-1:0];
                fin_val = r_res;
                n_state = atd_pkg::S_IDLE;
            end
            // read and descend
            atd_pkg::S_RD: begin
                va      = r_cmd.a;
                ga      = r_cmd.a;
                n_state = (r_cmd.op == atd_pkg::K_DESCEND) ? atd_pkg::S_DMUL
                                                           : atd_pkg::S_RDOUT;
            end
            atd_pkg::S_RDOUT: begin
                fin      = 1'b1;
                fin_val  = r_vrd;
                fin_grad = r_grd;
                n_state  = atd_pkg::S_IDLE;
            end
            atd_pkg::S_DMUL: begin
                n_state = atd_pkg::S_DUPD;
            end
            atd_pkg::S_DUPD: begin
                v_we     = 1'b1;
                v_wa     = r_cmd.a;
                v_wd     = desc_res;
                fin      = 1'b1;
                fin_val  = desc_res;
                fin_grad = r_g;
                n_state  = atd_pkg::S_IDLE;
            end
            // clear gradients one entry a cycle
            atd_pkg::S_ZERO: begin
                if (r_k == r_len) begin
                    fin     = 1'b1;
                    n_state = atd_pkg::S_IDLE;
                end else begin
                    g_we = 1'b1;
                    g_wa = r_k[AW-1:0];
                    g_wd = '0;
                end
            end
            // backprop walk, node r_k
            atd_pkg::S_BNODE: begin
                n_state = atd_pkg::S_BLINK;
            end
            atd_pkg::S_BLINK: begin
                va = r_l2rd;
                unique case (r_oprd)
                    atd_pkg::NODE_ADD, atd_pkg::NODE_SUB: n_state = atd_pkg::S_BAX;
                    atd_pkg::NODE_MUL:                    n_state = atd_pkg::S_BM1;
                    atd_pkg::NODE_TANH:                   n_state = atd_pkg::S_BT1;
                    default:                              n_state = atd_pkg::S_BNEXT;
                endcase
            end
            atd_pkg::S_BM1: begin
                va      = r_x;
                n_state = atd_pkg::S_BM2;
            end
            atd_pkg::S_BM2: begin
                n_state = atd_pkg::S_BM3;
            end
            atd_pkg::S_BM3: begin
                n_state = atd_pkg::S_BAX;
            end
            atd_pkg::S_BT1: begin
                n_state = atd_pkg::S_BT2;
            end
            atd_pkg::S_BT2: begin
                n_state = atd_pkg::S_BT3;
            end
            atd_pkg::S_BT3: begin
                n_state = atd_pkg::S_BT4;
            end
            atd_pkg::S_BT4: begin
                n_state = atd_pkg::S_BAX;
            end
            atd_pkg::S_BAX: begin
                ga      = r_x;
                n_state = atd_pkg::S_BAXW;
            end
            atd_pkg::S_BAXW: begin
                g_we    = 1'b1;
                g_wa    = r_x;
                g_wd    = atd_pkg::f_sat32(50'(r_grd) + 50'(r_dx));
                n_state = (r_op == atd_pkg::NODE_TANH) ? atd_pkg::S_BNEXT : atd_pkg::S_BAY;
            end
            atd_pkg::S_BAY: begin
                ga      = r_y;
                n_state = atd_pkg::S_BAYW;
            end
            atd_pkg::S_BAYW: begin
                g_we    = 1'b1;
                g_wa    = r_y;
                g_wd    = (r_op == atd_pkg::NODE_SUB)
                          ? atd_pkg::f_sat32(50'(r_grd) - 50'(r_dy))
                          : atd_pkg::f_sat32(50'(r_grd) + 50'(r_dy));
                n_state = atd_pkg::S_BNEXT;
            end
            atd_pkg::S_BNEXT: begin
                if (r_k == '0) begin
                    fin     = 1'b1;
                    n_state = atd_pkg::S_IDLE;
                end else begin
                    n_state = atd_pkg::S_BNODE;
                end
            end
            default: begin
                n_state = atd_pkg::S_IDLE;
            end
        endcase
    end

    // state, length and done strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= atd_pkg::S_IDLE;
            r_len   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_done  <= fin;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (fin) begin
            o_status      <= 2'(fin_status);
            o_node_index  <= fin_idx;
            o_node_value  <= fin_val;
            o_node_grad   <= fin_grad;
            o_tape_length <= n_len;
        end
    end

    assign o_done = r_done;

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= 65'(m_a) * 65'(m_b);
        unique case (r_state)
            atd_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    r_cmd <= i_q_cmd;
                end
            end
            atd_pkg::S_CHECK: begin
                r_res <= r_cmd.cval;
                r_k   <= (r_cmd.op == atd_pkg::K_BACKPROP) ? a_ext : '0;
            end
            atd_pkg::S_RDB:  r_opa <= r_vrd;
            atd_pkg::S_CALC: r_res <= calc_res;
            atd_pkg::S_MULF: r_res <= prod_sat;
            atd_pkg::S_DMUL: begin
                r_opa <= r_vrd;
                r_g   <= r_grd;
            end
            atd_pkg::S_ZERO: begin
                if (r_k != r_len) begin
                    r_k <= r_k + LW'(1);
                end
            end
            atd_pkg::S_BLINK: begin
                r_op <= r_oprd;
                r_x  <= r_l1rd;
                r_y  <= r_l2rd;
                r_g  <= r_grd;
                r_vk <= r_vrd;
                r_dx <= r_grd;
                r_dy <= r_grd;
            end
            atd_pkg::S_BM2: r_dx <= prod_sat;
            atd_pkg::S_BM3: r_dy <= prod_sat;
            atd_pkg::S_BT2: r_dy <= atd_pkg::f_sat32(50'(atd_pkg::FX_ONE) - 50'(prod_sat));
            atd_pkg::S_BT4: r_dx <= prod_sat;
            atd_pkg::S_BNEXT: begin
                if (r_k != '0) begin
                    r_k <= r_k - LW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // value memory
    always_ff @(posedge i_clk) begin
        if (v_we) begin
            value_mem[v_wa] <= v_wd;
        end
        r_vrd <= value_mem[va];
    end

    // gradient memory
    always_ff @(posedge i_clk) begin
        if (g_we) begin
            grad_mem[g_wa] <= g_wd;
        end
        r_grd <= grad_mem[ga];
    end

    // node op and link memories
    always_ff @(posedge i_clk) begin
        if (n_we) begin
            op_mem[r_len[AW-1:0]]    <= r_cmd.node_op;
            link1_mem[r_len[AW-1:0]] <= n_l1;
            link2_mem[r_len[AW-1:0]] <= r_cmd.use_b ? r_cmd.b : '0;
        end
        r_oprd <= op_mem[r_k[AW-1:0]];
        r_l1rd <= link1_mem[r_k[AW-1:0]];
        r_l2rd <= link2_mem[r_k[AW-1:0]];
    end

    // checks
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(atd_pkg::TAPE_DEPTH))
        else $error("tape length beyond depth");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == atd_pkg::S_IDLE)
        else $error("queue popped while busy");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && o_status == 2'(atd_pkg::ST_FULL))
            |-> o_tape_length == LW'(atd_pkg::TAPE_DEPTH))
        else $error("full status below depth");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("back-to-back done strobes");

endmodule

`default_nettype wire

[rtl/core/autodiff_tape_engine.sv]
// autodiff_tape_engine: top level of the reverse-mode differentiation tape engine
// depends on atd_pkg, atd_front, atd_queue, atd_back
//
// Usage:
//   Command channel: a word (kind, operands, mark, constant) is taken at a rising
//   edge with start high and busy low. busy stays high until its result is shown.
//   Result channel: o_done is high for exactly one cycle with status, node index,
//   value, gradient and tape length; the receiver cannot stall it.
//   Config channel: i_cfg_data (learn rate, Q1.16) is written when i_cfg_valid is
//   high; o_cfg_ready is always high. Write only while busy is low.
// The backprop walk is bound by the registered gradient read, which
// must come back before the write of every link updated.
// One command is in flight at a time; the next may start the cycle after o_done.
// Reset: tape length to zero, learn rate to 655; the tape memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module autodiff_tape_engine (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [3:0]          i_kind,
    input  wire logic [9:0]          i_operand_a,
    input  wire logic [9:0]          i_operand_b,
    input  wire logic [10:0]         i_mark,
    input  wire logic signed [31:0]  i_const_value,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [16:0]         i_cfg_data,
    output logic                     o_done,
    output logic [1:0]               o_status,
    output logic [9:0]               o_node_index,
    output logic signed [31:0]       o_node_value,
    output logic signed [31:0]       o_node_grad,
    output logic [10:0]              o_tape_length
);

    logic          cfg_wr;
    logic [16:0]   r_lr;
    logic          f_push;
    atd_pkg::t_cmd f_cmd;
    logic          q_valid;
    atd_pkg::t_cmd q_cmd;
    logic          q_pop;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // learn rate register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr <= atd_pkg::LR_RESET;
        end else if (cfg_wr) begin
            r_lr <= i_cfg_data;
        end
    end

    atd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .i_mark        (i_mark),
        .i_const_value (i_const_value),
        .i_done        (o_done),
        .o_push        (f_push),
        .o_cmd         (f_cmd)
    );

    atd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    atd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_cmd),
        .o_pop         (q_pop),
        .i_learn_rate  (r_lr),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_node_index  (o_node_index),
        .o_node_value  (o_node_value),
        .o_node_grad   (o_node_grad),
        .o_tape_length (o_tape_length)
    );

endmodule

`default_nettype wire

[sim/autodiff_tape_chk.sv]
// autodiff_tape_chk: predicts every result word of the autodiff tape engine and checks it
// watches the command, config and result channels; depends on atd_pkg for codes
`timescale 1ns / 1ps

module autodiff_tape_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [3:0]         i_kind,
    input  logic [9:0]         i_operand_a,
    input  logic [9:0]         i_operand_b,
    input  logic [10:0]        i_mark,
    input  logic signed [31:0] i_const_value,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [16:0]        i_cfg_data,
    input  logic               i_done,
    input  logic [1:0]         i_status,
    input  logic [9:0]         i_node_index,
    input  logic signed [31:0] i_node_value,
    input  logic signed [31:0] i_node_grad,
    input  logic [10:0]        i_tape_length,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct packed {
        logic [1:0]         status;
        logic [9:0]         index;
        logic signed [31:0] value;
        logic signed [31:0] grad;
        logic [10:0]        length;
    } t_word;

    // shadow tape
    logic signed [31:0]  tape_val  [atd_pkg::TAPE_DEPTH];
    logic signed [31:0]  tape_grad [atd_pkg::TAPE_DEPTH];
    atd_pkg::t_node_op   tape_op   [atd_pkg::TAPE_DEPTH];
    logic [9:0]          tape_x    [atd_pkg::TAPE_DEPTH];
    logic [9:0]          tape_y    [atd_pkg::TAPE_DEPTH];
    logic signed [31:0]  tanh_lut  [atd_pkg::TANH_ENTRIES];
    int                  tape_len;
    logic [16:0]         rate;
    t_word               expected_words [$];

    // tanh at each step midpoint, rounded to nearest
    initial begin
        real m;
        int  s;
        for (int i = 0; i < atd_pkg::TANH_ENTRIES; i++) begin
            s = 2 * i + 1 - atd_pkg::TANH_ENTRIES;
            m = ((s < 0) ? -s : s) * 4.0 / atd_pkg::TANH_ENTRIES;
            tanh_lut[i] = $rtoi($tanh(m) * 65536.0 + 0.5);
            if (s < 0) tanh_lut[i] = -tanh_lut[i];
        end
    end

    function automatic logic signed [31:0] clamp32(input longint x);
        if (x > 64'sd2147483647) return 32'sh7fff_ffff;
        if (x < -64'sd2147483648) return 32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] qadd(input logic signed [31:0] p, q);
        return clamp32(longint'(p) + longint'(q));
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] p, q);
        return clamp32(longint'(p) - longint'(q));
    endfunction

    function automatic logic signed [31:0] qmul(input logic signed [31:0] p, q);
        longint prod;
        prod = longint'(p) * longint'(q);
        return clamp32(prod >>> 16);
    endfunction

    function automatic logic signed [31:0] qtanh(input logic signed [31:0] v);
        longint t;
        longint idx;
        t = longint'(v) + 64'sd262144;
        idx = (t > 0) ? (t >>> 11) : 0;
        if (idx > atd_pkg::TANH_ENTRIES - 1) idx = atd_pkg::TANH_ENTRIES - 1;
        return tanh_lut[idx];
    endfunction

    // walk the tape down from the seed node, passing gradients to inputs
    task automatic backprop_walk(input int seed);
        logic signed [31:0] g;
        logic signed [31:0] slope;
        int                 x;
        int                 y;
        tape_grad[seed] = atd_pkg::FX_ONE;
        for (int k = seed; k >= 0; k--) begin
            x = tape_x[k];
            y = tape_y[k];
            g = tape_grad[k];
            case (tape_op[k])
                atd_pkg::NODE_ADD: begin
                    tape_grad[x] = qadd(tape_grad[x], g);
                    tape_grad[y] = qadd(tape_grad[y], g);
                end
                atd_pkg::NODE_SUB: begin
                    tape_grad[x] = qadd(tape_grad[x], g);
                    tape_grad[y] = qsub(tape_grad[y], g);
                end
                atd_pkg::NODE_MUL: begin
                    tape_grad[x] = qadd(tape_grad[x], qmul(g, tape_val[y]));
                    tape_grad[y] = qadd(tape_grad[y], qmul(g, tape_val[x]));
                end
                atd_pkg::NODE_TANH: begin
                    slope = qsub(atd_pkg::FX_ONE, qmul(tape_val[k], tape_val[k]));
                    tape_grad[x] = qadd(tape_grad[x], qmul(slope, g));
                end
                default: ;
            endcase
        end
    endtask

    // apply one command word to the shadow tape and build its result word
    task automatic predict_word(output t_word w);
        int                 a;
        int                 b;
        int                 p;
        logic               two_ops;
        logic signed [31:0] v;
        longint             step;
        a = i_operand_a;
        b = i_operand_b;
        w = '{atd_pkg::ST_OK, 10'd0, 32'sd0, 32'sd0, 11'd0};
        two_ops = (i_kind == atd_pkg::K_ADD) || (i_kind == atd_pkg::K_SUB)
                  || (i_kind == atd_pkg::K_MUL);
        case (i_kind)
            atd_pkg::K_CONST, atd_pkg::K_ADD, atd_pkg::K_SUB, atd_pkg::K_MUL,
            atd_pkg::K_TANH: begin
                if (i_kind != atd_pkg::K_CONST
                    && (a >= tape_len || (two_ops && b >= tape_len))) begin
                    w.status = atd_pkg::ST_INDEX;
                end else if (tape_len >= atd_pkg::TAPE_DEPTH) begin
                    w.status = atd_pkg::ST_FULL;
                end else begin
                    p = tape_len;
                    case (i_kind)
                        atd_pkg::K_CONST: v = i_const_value;
                        atd_pkg::K_ADD:   v = qadd(tape_val[a], tape_val[b]);
                        atd_pkg::K_SUB:   v = qsub(tape_val[a], tape_val[b]);
                        atd_pkg::K_MUL:   v = qmul(tape_val[a], tape_val[b]);
                        default:          v = qtanh(tape_val[a]);
                    endcase
                    tape_val[p]  = v;
                    tape_grad[p] = 32'sd0;
                    tape_op[p]   = atd_pkg::t_node_op'(i_kind[2:0]);
                    tape_x[p]    = (i_kind == atd_pkg::K_CONST) ? 10'(p) : 10'(a);
                    tape_y[p]    = two_ops ? 10'(b) : 10'd0;
                    tape_len     = p + 1;
                    w.index      = 10'(p);
                    w.value      = v;
                end
            end
            atd_pkg::K_READ: begin
                if (a >= tape_len) begin
                    w.status = atd_pkg::ST_INDEX;
                end else begin
                    w.value = tape_val[a];
                    w.grad  = tape_grad[a];
                end
            end
            atd_pkg::K_BACKPROP: begin
                if (a >= tape_len) w.status = atd_pkg::ST_INDEX;
                else backprop_walk(a);
            end
            atd_pkg::K_ZERO: begin
                for (int k = 0; k < tape_len; k++) tape_grad[k] = 32'sd0;
            end
            atd_pkg::K_TRUNC: begin
                if (i_mark > tape_len) w.status = atd_pkg::ST_MARK;
                else tape_len = i_mark;
            end
            atd_pkg::K_DESCEND: begin
                if (a >= tape_len) begin
                    w.status = atd_pkg::ST_INDEX;
                end else begin
                    step = (longint'(tape_grad[a]) * longint'({1'b0, rate})) >>> 16;
                    tape_val[a] = clamp32(longint'(tape_val[a]) - step);
                    w.value = tape_val[a];
                    w.grad  = tape_grad[a];
                end
            end
            default: ;
        endcase
        w.length = 11'(tape_len);
    endtask

    // result check, config tracking and prediction on each edge
    always @(posedge i_clk) begin
        t_word w;
        t_word got;
        if (!i_rst_n) begin
            tape_len = 0;
            rate     = atd_pkg::LR_RESET;
            expected_words.delete();
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (i_done) begin
                got = '{i_status, i_node_index, i_node_value, i_node_grad, i_tape_length};
                if (expected_words.size() == 0) begin
                    $display("%0t: result word with none expected", $time);
                    o_errors <= o_errors + 1;
                end else begin
                    w = expected_words.pop_front();
                    if (got != w) begin
                        $display("%0t: status exp %0d got %0d, index exp %0d got %0d",
                                 $time, w.status, got.status, w.index, got.index);
                        $display("%0t: value exp %0d got %0d, grad exp %0d got %0d",
                                 $time, w.value, got.value, w.grad, got.grad);
                        $display("%0t: length exp %0d got %0d",
                                 $time, w.length, got.length);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) rate = i_cfg_data;
            if (start && !busy) begin
                predict_word(w);
                expected_words.push_back(w);
            end
            o_pending <= expected_words.size();
        end
    end

endmodule

[sim/autodiff_tape_engine_tb.sv]
// autodiff_tape_engine_tb: command stimulus and verdict for the autodiff tape engine
// depends on atd_pkg, autodiff_tape_engine and autodiff_tape_chk
`timescale 1ns / 1ps

module autodiff_tape_engine_tb;

    localparam int STALL_LIMIT = 60000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic [3:0]         i_kind = '0;
    logic [9:0]         i_operand_a = '0;
    logic [9:0]         i_operand_b = '0;
    logic [10:0]        i_mark = '0;
    logic signed [31:0] i_const_value = '0;
    logic               i_cfg_valid = 1'b0;
    logic [16:0]        i_cfg_data = '0;
    logic               busy;
    logic               o_cfg_ready;
    logic               o_done;
    logic [1:0]         o_status;
    logic [9:0]         o_node_index;
    logic signed [31:0] o_node_value;
    logic signed [31:0] o_node_grad;
    logic [10:0]        o_tape_length;
    int                 errors;
    int                 pending;
    int                 tape_len = 0;
    int                 idle_cycles = 0;
    int                 words_sent = 0;
    logic               gaps_on = 1'b1;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    autodiff_tape_engine dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_kind(i_kind), .i_operand_a(i_operand_a), .i_operand_b(i_operand_b),
        .i_mark(i_mark), .i_const_value(i_const_value),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_done(o_done), .o_status(o_status), .o_node_index(o_node_index),
        .o_node_value(o_node_value), .o_node_grad(o_node_grad),
        .o_tape_length(o_tape_length)
    );

    autodiff_tape_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_kind(i_kind), .i_operand_a(i_operand_a), .i_operand_b(i_operand_b),
        .i_mark(i_mark), .i_const_value(i_const_value),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_done(o_done), .i_status(o_status), .i_node_index(o_node_index),
        .i_node_value(o_node_value), .i_node_grad(o_node_grad),
        .i_tape_length(o_tape_length), .o_errors(errors), .o_pending(pending)
    );

    // stall watchdog, cleared by any accepted word or result word
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // send one command word and wait for its result word
    task automatic send(input logic [3:0] k, input int a, input int b, input int m,
                        input logic signed [31:0] c);
        if (gaps_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 13)) @(posedge i_clk);
        @(posedge i_clk);
        start         <= 1'b1;
        i_kind        <= k;
        i_operand_a   <= 10'(a);
        i_operand_b   <= 10'(b);
        i_mark        <= 11'(m);
        i_const_value <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        start <= 1'b0;
        do @(posedge i_clk); while (!o_done);
        tape_len = o_tape_length;
        words_sent++;
    endtask

    task automatic push_const(input logic signed [31:0] c);
        send(atd_pkg::K_CONST, $urandom, $urandom, $urandom, c);
    endtask

    // learn rate write while the engine is idle
    task automatic write_rate(input logic [16:0] r);
        while (pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= r;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 2 * 65536) - 65536;
            default: return $urandom_range(0, 10 * 65536) - 5 * 65536;
        endcase
    endfunction

    // one random word, mostly well formed against the current tape
    task automatic random_word();
        int r;
        int a;
        int b;
        a = (tape_len > 0) ? $urandom_range(0, tape_len - 1) : 0;
        b = (tape_len > 0) ? $urandom_range(0, tape_len - 1) : 0;
        r = $urandom_range(0, 99);
        if (tape_len == 0 || r >= 85) push_const(rand_value());
        else if (tape_len > 40) send(atd_pkg::K_TRUNC, a, b, $urandom_range(0, tape_len), 0);
        else if (r < 45) send(4'($urandom_range(atd_pkg::K_ADD, atd_pkg::K_TANH)), a, b, 0,
                              $urandom);
        else if (r < 52) send(atd_pkg::K_READ, a, $urandom, $urandom, $urandom);
        else if (r < 58) send(atd_pkg::K_BACKPROP, a, $urandom, $urandom, $urandom);
        else if (r < 64) send(atd_pkg::K_DESCEND, a, $urandom, $urandom, $urandom);
        else if (r < 67) send(atd_pkg::K_ZERO, $urandom, $urandom, $urandom, $urandom);
        else if (r < 75) send(atd_pkg::K_TRUNC, a, b, $urandom_range(0, tape_len), 0);
        else send(4'($urandom), $urandom, $urandom, $urandom, $urandom);
    endtask

    initial begin
        logic [16:0] rates [5];
        rates = '{17'd0, 17'd65536, 17'h1ffff, 17'($urandom), 17'd1};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, saturation, tanh ends, bad indexes and marks
        push_const(32'sh7fff_ffff);
        push_const(32'sh8000_0000);
        push_const(32'sd0);
        push_const(atd_pkg::FX_ONE);
        send(atd_pkg::K_ADD, 0, 0, 0, 0);
        send(atd_pkg::K_SUB, 1, 0, 0, 0);
        send(atd_pkg::K_MUL, 0, 1, 0, 0);
        send(atd_pkg::K_MUL, 3, 1, 0, 0);
        send(atd_pkg::K_TANH, 1, 0, 0, 0);
        send(atd_pkg::K_TANH, 0, 0, 0, 0);
        send(atd_pkg::K_TANH, 3, 0, 0, 0);
        send(atd_pkg::K_ADD, 3, 1023, 0, 0);
        send(atd_pkg::K_READ, 1023, 0, 0, 0);
        send(atd_pkg::K_BACKPROP, 10, 0, 0, 0);
        send(atd_pkg::K_READ, 3, 0, 0, 0);
        send(atd_pkg::K_DESCEND, 3, 0, 0, 0);
        send(atd_pkg::K_DESCEND, 1023, 0, 0, 0);
        send(atd_pkg::K_ZERO, 0, 0, 0, 0);
        send(atd_pkg::K_TRUNC, 0, 0, 1024, 0);
        send(atd_pkg::K_TRUNC, 0, 0, 4, 0);
        send(4'd15, 1023, 1023, 2047, 32'shffff_ffff);
        send(4'd10, 0, 0, 0, 0);

        // random phases, each at its own learn rate
        for (int ph = 0; ph < 5; ph++) begin
            write_rate(rates[ph]);
            gaps_on = (ph < 4);
            for (int n = 0; n < 186; n++) begin
                random_word();
                // hold off until all results are in, now and then
                if (n == 100) while (pending != 0) @(posedge i_clk);
            end
        end

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("ran %0d command words: all kinds, saturation, tanh ends, bad operands",
                 words_sent);
        $display("learn rate taken through reset value, zero, one, max and random");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/atd_pkg.sv
rtl/core/atd_front.sv
rtl/core/atd_queue.sv
rtl/core/atd_back.sv
rtl/core/autodiff_tape_engine.sv
sim/autodiff_tape_chk.sv
sim/autodiff_tape_engine_tb.sv
